[src/jtl_pkg.sv]
// Shared types, codes and literal tables of the JSON token lexer.
package jtl_pkg;

	typedef enum logic [3:0] {
		M_IDLE  = 4'd0,
		M_STR   = 4'd1,
		M_ESC   = 4'd2,
		M_NSIGN = 4'd3,
		M_NZERO = 4'd4,
		M_NINT  = 4'd5,
		M_NDOT  = 4'd6,
		M_NFRAC = 4'd7,
		M_LIT   = 4'd8,
		M_HALT  = 4'd9
	} mode_t;

	localparam logic [3:0] KIND_STRING   = 4'd0;
	localparam logic [3:0] KIND_NUMBER   = 4'd1;
	localparam logic [3:0] KIND_LBRACE   = 4'd2;
	localparam logic [3:0] KIND_COLON    = 4'd3;
	localparam logic [3:0] KIND_RBRACE   = 4'd4;
	localparam logic [3:0] KIND_LBRACKET = 4'd5;
	localparam logic [3:0] KIND_COMMA    = 4'd6;
	localparam logic [3:0] KIND_RBRACKET = 4'd7;
	localparam logic [3:0] KIND_TRUE     = 4'd8;
	localparam logic [3:0] KIND_END      = 4'd11;
	localparam logic [3:0] KIND_ERROR    = 4'd12;

	localparam logic [1:0] ERR_OK     = 2'd0;
	localparam logic [1:0] ERR_STRING = 2'd1;
	localparam logic [1:0] ERR_NUMBER = 2'd2;
	localparam logic [1:0] ERR_TOKEN  = 2'd3;

	localparam logic [7:0] CH_TAB      = 8'h09;
	localparam logic [7:0] CH_LF       = 8'h0A;
	localparam logic [7:0] CH_CR       = 8'h0D;
	localparam logic [7:0] CH_SPACE    = 8'h20;
	localparam logic [7:0] CH_QUOTE    = 8'h22;
	localparam logic [7:0] CH_COMMA    = 8'h2C;
	localparam logic [7:0] CH_MINUS    = 8'h2D;
	localparam logic [7:0] CH_DOT      = 8'h2E;
	localparam logic [7:0] CH_SLASH    = 8'h2F;
	localparam logic [7:0] CH_ZERO     = 8'h30;
	localparam logic [7:0] CH_ONE      = 8'h31;
	localparam logic [7:0] CH_NINE     = 8'h39;
	localparam logic [7:0] CH_COLON    = 8'h3A;
	localparam logic [7:0] CH_LBRACKET = 8'h5B;
	localparam logic [7:0] CH_BSLASH   = 8'h5C;
	localparam logic [7:0] CH_RBRACKET = 8'h5D;
	localparam logic [7:0] CH_LOW_B    = 8'h62;
	localparam logic [7:0] CH_LOW_F    = 8'h66;
	localparam logic [7:0] CH_LOW_N    = 8'h6E;
	localparam logic [7:0] CH_LOW_R    = 8'h72;
	localparam logic [7:0] CH_LOW_T    = 8'h74;
	localparam logic [7:0] CH_LBRACE   = 8'h7B;
	localparam logic [7:0] CH_RBRACE   = 8'h7D;

	localparam logic [1:0] LIT_TRUE  = 2'd0;
	localparam logic [1:0] LIT_FALSE = 2'd1;
	localparam logic [1:0] LIT_NULL  = 2'd2;

	localparam int QUEUE_DEPTH = 4;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		mode_t       mode;
		logic [1:0]  lsel;
		logic [2:0]  lidx;
		logic [31:0] start;
		logic [31:0] run;
	} lex_state_t;

	typedef struct packed {
		logic [3:0]  kind;
		logic [1:0]  code;
		logic [31:0] start;
		logic [31:0] length;
	} result_t;

	typedef struct packed {
		result_t res;
		logic    last;
	} entry_t;

	function automatic logic [2:0] lit_len(input logic [1:0] sel);
		logic [2:0] len;
		unique case (sel)
			LIT_TRUE:  len = 3'd4;
			LIT_FALSE: len = 3'd5;
			LIT_NULL:  len = 3'd4;
			default:   len = 3'd0;
		endcase
		return len;
	endfunction

	function automatic logic [7:0] lit_char(input logic [1:0] sel, input logic [2:0] idx);
		logic [39:0] text;
		unique case (sel)
			LIT_TRUE:  text = {"true", 8'h00};
			LIT_FALSE: text = "false";
			LIT_NULL:  text = {"null", 8'h00};
			default:   text = '0;
		endcase
		return (idx < 3'd5) ? text[8*(4 - 32'(idx)) +: 8] : 8'h00;
	endfunction

endpackage

[src/jtl_next.sv]
// Next-state and result logic of the lexer for one accepted byte.
module jtl_next #(
	parameter int POSITION_BITS = 32
) (
	input  jtl_pkg::lex_state_t       cur,
	input  logic [POSITION_BITS-1:0]  pos,
	input  logic [7:0]                text_byte,
	input  logic                      end_of_input,
	output jtl_pkg::lex_state_t       nxt,
	output logic [POSITION_BITS-1:0]  pos_d,
	output logic [1:0]                n_res,
	output jtl_pkg::result_t          res0,
	output jtl_pkg::result_t          res1
);

	localparam int SW = (POSITION_BITS < 32) ? POSITION_BITS : 32;

	logic [31:0] pos32;
	logic [31:0] run_inc;
	logic        is_end;
	logic        is_digit;

	jtl_pkg::mode_t   id_mode;
	logic             id_begin;
	logic             id_lit;
	logic [1:0]       id_sel;
	logic             id_emit;
	jtl_pkg::result_t id_res;

	logic       take_idle;
	logic       idle_slot1;
	logic [2:0] lidx_inc;

	assign pos32    = 32'(pos[SW-1:0]);
	assign run_inc  = (cur.run == '1) ? cur.run : cur.run + 32'd1;
	assign is_end   = end_of_input | (text_byte == 8'h00);
	assign is_digit = (text_byte >= jtl_pkg::CH_ZERO) && (text_byte <= jtl_pkg::CH_NINE);
	assign lidx_inc = cur.lidx + 3'd1;

	// Decode of a byte seen between tokens.
	always_comb begin
		id_mode  = jtl_pkg::M_IDLE;
		id_begin = 1'b0;
		id_lit   = 1'b0;
		id_sel   = jtl_pkg::LIT_TRUE;
		id_emit  = 1'b0;
		id_res   = '{kind: jtl_pkg::KIND_ERROR, code: jtl_pkg::ERR_OK,
			start: pos32, length: 32'd1};
		case (text_byte)
			jtl_pkg::CH_TAB, jtl_pkg::CH_LF, jtl_pkg::CH_CR, jtl_pkg::CH_SPACE: begin
			end
			jtl_pkg::CH_LBRACE: begin
				id_emit = 1'b1; id_res.kind = jtl_pkg::KIND_LBRACE;
			end
			jtl_pkg::CH_COLON: begin
				id_emit = 1'b1; id_res.kind = jtl_pkg::KIND_COLON;
			end
			jtl_pkg::CH_RBRACE: begin
				id_emit = 1'b1; id_res.kind = jtl_pkg::KIND_RBRACE;
			end
			jtl_pkg::CH_LBRACKET: begin
				id_emit = 1'b1; id_res.kind = jtl_pkg::KIND_LBRACKET;
			end
			jtl_pkg::CH_COMMA: begin
				id_emit = 1'b1; id_res.kind = jtl_pkg::KIND_COMMA;
			end
			jtl_pkg::CH_RBRACKET: begin
				id_emit = 1'b1; id_res.kind = jtl_pkg::KIND_RBRACKET;
			end
			jtl_pkg::CH_QUOTE: begin
				id_mode = jtl_pkg::M_STR; id_begin = 1'b1;
			end
			jtl_pkg::CH_MINUS: begin
				id_mode = jtl_pkg::M_NSIGN; id_begin = 1'b1;
			end
			jtl_pkg::CH_ZERO: begin
				id_mode = jtl_pkg::M_NZERO; id_begin = 1'b1;
			end
			jtl_pkg::CH_LOW_T: begin
				id_mode = jtl_pkg::M_LIT; id_begin = 1'b1; id_lit = 1'b1;
				id_sel = jtl_pkg::LIT_TRUE;
			end
			jtl_pkg::CH_LOW_F: begin
				id_mode = jtl_pkg::M_LIT; id_begin = 1'b1; id_lit = 1'b1;
				id_sel = jtl_pkg::LIT_FALSE;
			end
			jtl_pkg::CH_LOW_N: begin
				id_mode = jtl_pkg::M_LIT; id_begin = 1'b1; id_lit = 1'b1;
				id_sel = jtl_pkg::LIT_NULL;
			end
			default: begin
				if (text_byte >= jtl_pkg::CH_ONE && text_byte <= jtl_pkg::CH_NINE) begin
					id_mode  = jtl_pkg::M_NINT;
					id_begin = 1'b1;
				end else begin
					id_mode      = jtl_pkg::M_HALT;
					id_emit      = 1'b1;
					id_res.code  = jtl_pkg::ERR_TOKEN;
				end
			end
		endcase
	end

	always_comb begin
		nxt        = cur;
		pos_d      = pos;
		n_res      = 2'd0;
		res0       = '0;
		res1       = '0;
		take_idle  = 1'b0;
		idle_slot1 = 1'b0;
		if (is_end) begin
			case (cur.mode)
				jtl_pkg::M_STR, jtl_pkg::M_ESC: begin
					res0  = '{jtl_pkg::KIND_ERROR, jtl_pkg::ERR_STRING, cur.start, cur.run};
					n_res = 2'd1;
				end
				jtl_pkg::M_NSIGN, jtl_pkg::M_NDOT: begin
					res0  = '{jtl_pkg::KIND_ERROR, jtl_pkg::ERR_NUMBER, cur.start, cur.run};
					n_res = 2'd1;
				end
				jtl_pkg::M_NZERO, jtl_pkg::M_NINT, jtl_pkg::M_NFRAC: begin
					res0  = '{jtl_pkg::KIND_NUMBER, jtl_pkg::ERR_OK, cur.start, cur.run};
					n_res = 2'd1;
				end
				jtl_pkg::M_LIT: begin
					res0  = '{jtl_pkg::KIND_ERROR, jtl_pkg::ERR_TOKEN, cur.start, cur.run};
					n_res = 2'd1;
				end
				default: begin
				end
			endcase
			if (n_res == 2'd0) begin
				res0 = '{jtl_pkg::KIND_END, jtl_pkg::ERR_OK, pos32, 32'd0};
			end else begin
				res1 = '{jtl_pkg::KIND_END, jtl_pkg::ERR_OK, pos32, 32'd0};
			end
			n_res = n_res + 2'd1;
			nxt   = '{mode: jtl_pkg::M_IDLE, lsel: 2'd0, lidx: 3'd0, start: 32'd0, run: 32'd0};
			pos_d = '0;
		end else if (cur.mode != jtl_pkg::M_HALT) begin
			pos_d = pos + POSITION_BITS'(1);
			case (cur.mode)
				jtl_pkg::M_STR: begin
					nxt.run = run_inc;
					if (text_byte == jtl_pkg::CH_BSLASH) begin
						nxt.mode = jtl_pkg::M_ESC;
					end else if (text_byte == jtl_pkg::CH_QUOTE) begin
						res0     = '{jtl_pkg::KIND_STRING, jtl_pkg::ERR_OK, cur.start, run_inc};
						n_res    = 2'd1;
						nxt.mode = jtl_pkg::M_IDLE;
					end
				end
				jtl_pkg::M_ESC: begin
					if (text_byte == jtl_pkg::CH_QUOTE || text_byte == jtl_pkg::CH_BSLASH ||
						text_byte == jtl_pkg::CH_SLASH || text_byte == jtl_pkg::CH_LOW_B ||
						text_byte == jtl_pkg::CH_LOW_F || text_byte == jtl_pkg::CH_LOW_N ||
						text_byte == jtl_pkg::CH_LOW_R || text_byte == jtl_pkg::CH_LOW_T) begin
						nxt.run  = run_inc;
						nxt.mode = jtl_pkg::M_STR;
					end else begin
						res0     = '{jtl_pkg::KIND_ERROR, jtl_pkg::ERR_STRING, cur.start, run_inc};
						n_res    = 2'd1;
						nxt.mode = jtl_pkg::M_HALT;
					end
				end
				jtl_pkg::M_NSIGN: begin
					if (text_byte == jtl_pkg::CH_ZERO) begin
						nxt.run = run_inc; nxt.mode = jtl_pkg::M_NZERO;
					end else if (is_digit) begin
						nxt.run = run_inc; nxt.mode = jtl_pkg::M_NINT;
					end else begin
						res0     = '{jtl_pkg::KIND_ERROR, jtl_pkg::ERR_NUMBER, cur.start, run_inc};
						n_res    = 2'd1;
						nxt.mode = jtl_pkg::M_HALT;
					end
				end
				jtl_pkg::M_NZERO, jtl_pkg::M_NINT, jtl_pkg::M_NFRAC: begin
					if (is_digit && cur.mode != jtl_pkg::M_NZERO) begin
						nxt.run = run_inc;
					end else if (text_byte == jtl_pkg::CH_DOT && cur.mode != jtl_pkg::M_NFRAC) begin
						nxt.run = run_inc; nxt.mode = jtl_pkg::M_NDOT;
					end else begin
						// The number ends here and this byte starts over between tokens.
						res0       = '{jtl_pkg::KIND_NUMBER, jtl_pkg::ERR_OK, cur.start, cur.run};
						n_res      = 2'd1;
						take_idle  = 1'b1;
						idle_slot1 = 1'b1;
					end
				end
				jtl_pkg::M_NDOT: begin
					if (is_digit) begin
						nxt.run = run_inc; nxt.mode = jtl_pkg::M_NFRAC;
					end else begin
						res0     = '{jtl_pkg::KIND_ERROR, jtl_pkg::ERR_NUMBER, cur.start, run_inc};
						n_res    = 2'd1;
						nxt.mode = jtl_pkg::M_HALT;
					end
				end
				jtl_pkg::M_LIT: begin
					if (cur.lidx < jtl_pkg::lit_len(cur.lsel) &&
						text_byte == jtl_pkg::lit_char(cur.lsel, cur.lidx)) begin
						nxt.run  = run_inc;
						nxt.lidx = lidx_inc;
						if (lidx_inc == jtl_pkg::lit_len(cur.lsel)) begin
							res0     = '{jtl_pkg::KIND_TRUE + {2'b00, cur.lsel}, jtl_pkg::ERR_OK,
								cur.start, run_inc};
							n_res    = 2'd1;
							nxt.mode = jtl_pkg::M_IDLE;
							nxt.lsel = 2'd0;
							nxt.lidx = 3'd0;
						end
					end else begin
						res0     = '{jtl_pkg::KIND_ERROR, jtl_pkg::ERR_TOKEN, cur.start, run_inc};
						n_res    = 2'd1;
						nxt.mode = jtl_pkg::M_HALT;
					end
				end
				default: begin
					take_idle = 1'b1;
				end
			endcase
			if (take_idle) begin
				nxt.mode = id_mode;
				if (id_begin) begin
					nxt.start = pos32;
					nxt.run   = 32'd1;
				end
				if (id_lit) begin
					nxt.lsel = id_sel;
					nxt.lidx = 3'd1;
				end
				if (id_emit) begin
					if (idle_slot1) begin
						res1  = id_res;
						n_res = 2'd2;
					end else begin
						res0  = id_res;
						n_res = 2'd1;
					end
				end
			end
		end
	end

endmodule

[src/jtl_result_queue.sv]
// Small result queue that takes up to two tokens a cycle and delivers one.
module jtl_result_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [1:0]       push_n,
	input  jtl_pkg::result_t push0,
	input  jtl_pkg::result_t push1,
	input  logic             pop,
	output jtl_pkg::entry_t  head,
	output logic             head_valid,
	output logic             room
);

	jtl_pkg::entry_t mem_q [jtl_pkg::QUEUE_DEPTH];

	logic [jtl_pkg::PTR_W-1:0] wr_q;
	logic [jtl_pkg::PTR_W-1:0] rd_q;
	logic [jtl_pkg::PTR_W:0]   cnt_q;
	logic                      do_pop;

	assign head_valid = (cnt_q != '0);
	assign do_pop     = pop & head_valid;
	assign head       = mem_q[rd_q];
	// Room for the largest burst one byte can cause.
	assign room       = (cnt_q <= (jtl_pkg::PTR_W + 1)'(jtl_pkg::QUEUE_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wr_q] <= '{res: push0, last: (push_n == 2'd1)};
		end
		if (push_n == 2'd2) begin
			mem_q[wr_q + jtl_pkg::PTR_W'(1)] <= '{res: push1, last: 1'b1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + jtl_pkg::PTR_W'(push_n);
			rd_q  <= rd_q + jtl_pkg::PTR_W'(do_pop);
			cnt_q <= cnt_q + (jtl_pkg::PTR_W + 1)'(push_n) - (jtl_pkg::PTR_W + 1)'(do_pop);
		end
	end

endmodule

[src/json_token_lexer_core.sv]
// Top level of the streaming JSON token lexer.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+--------------------------------------
//  data    | in        | data_valid / data_ready   | text_byte, end_of_input
//  token   | out       | token_valid / token_ready | token_kind, error_code, token_start,
//          |           |                           | token_length, last
//
// One byte is taken per cycle while data_ready is high. The byte is decoded against the
// lexer mode register in a single combinational step and its tokens (none, one or two) are
// written into a four entry result queue, which delivers one token per cycle while
// token_ready is high. A byte that ends a number and is itself a punctuator or an unknown
// byte yields two tokens; data_ready drops only while the queue holds more than two tokens.
// Reset clears the mode, the literal tracker, the position and the queue pointers.
// A stall on the token side fills the queue and then holds off the data side.
module json_token_lexer_core #(
	parameter int POSITION_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        data_valid,
	output logic        data_ready,
	input  logic [7:0]  text_byte,
	input  logic        end_of_input,
	output logic        token_valid,
	input  logic        token_ready,
	output logic [3:0]  token_kind,
	output logic [1:0]  error_code,
	output logic [31:0] token_start,
	output logic [31:0] token_length,
	output logic        last
);

	// Lexer state: mode, literal tracker, token start and running length.
	jtl_pkg::lex_state_t      st_q;
	logic [POSITION_BITS-1:0] pos_q;

	jtl_pkg::lex_state_t      st_d;
	logic [POSITION_BITS-1:0] pos_d;
	logic [1:0]               n_res;
	jtl_pkg::result_t         res0;
	jtl_pkg::result_t         res1;

	logic            accept;
	logic            room;
	jtl_pkg::entry_t head;
	logic            end_mark;

	assign accept     = data_valid & data_ready;
	assign data_ready = room;
	assign end_mark   = end_of_input | (text_byte == 8'h00);

	jtl_next #(
		.POSITION_BITS(POSITION_BITS)
	) u_next (
		.cur         (st_q),
		.pos         (pos_q),
		.text_byte   (text_byte),
		.end_of_input(end_of_input),
		.nxt         (st_d),
		.pos_d       (pos_d),
		.n_res       (n_res),
		.res0        (res0),
		.res1        (res1)
	);

	// The state only moves when a byte is actually accepted.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= '{mode: jtl_pkg::M_IDLE, lsel: 2'd0, lidx: 3'd0, start: 32'd0, run: 32'd0};
			pos_q <= '0;
		end else if (accept) begin
			st_q  <= st_d;
			pos_q <= pos_d;
		end
	end

	jtl_result_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (accept ? n_res : 2'd0),
		.push0     (res0),
		.push1     (res1),
		.pop       (token_ready),
		.head      (head),
		.head_valid(token_valid),
		.room      (room)
	);

	assign token_kind   = head.res.kind;
	assign error_code   = head.res.code;
	assign token_start  = head.res.start;
	assign token_length = head.res.length;
	assign last         = head.last;

	// An end marker always returns the lexer to its reset state.
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && end_mark) |=> (st_q.mode == jtl_pkg::M_IDLE && pos_q == '0))
		else $error("lexer not rearmed after end marker");

	// Once halted, data bytes produce nothing until the end marker.
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !end_mark && st_q.mode == jtl_pkg::M_HALT) |-> (n_res == 2'd0))
		else $error("halted lexer produced a token");

	// Two tokens from one byte: a closed number first or an end token second.
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && n_res == 2'd2) |->
		(res0.kind == jtl_pkg::KIND_NUMBER || res1.kind == jtl_pkg::KIND_END))
		else $error("unexpected token pair");

endmodule

[dv/tb_top.sv]
// Self-checking testbench for the streaming JSON token lexer.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam int RANDOM_ITEMS = 1550;
	localparam int MAX_GAP = 16;
	// The receiver goes deaf once for this long so the result queue fills and
	// data_ready drops while the sender keeps offering bytes.
	localparam int CHOKE_AFTER = 150;
	localparam int CHOKE_CYCLES = 400;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 20;

	localparam logic [7:0] BLANKS [4] = '{jtl_pkg::CH_TAB, jtl_pkg::CH_LF, jtl_pkg::CH_CR,
		jtl_pkg::CH_SPACE};
	localparam logic [7:0] ESCAPES [8] = '{jtl_pkg::CH_QUOTE, jtl_pkg::CH_BSLASH,
		jtl_pkg::CH_SLASH, jtl_pkg::CH_LOW_B, jtl_pkg::CH_LOW_F, jtl_pkg::CH_LOW_N,
		jtl_pkg::CH_LOW_R, jtl_pkg::CH_LOW_T};
	localparam logic [7:0] PUNCTS [6] = '{jtl_pkg::CH_LBRACE, jtl_pkg::CH_COLON,
		jtl_pkg::CH_RBRACE, jtl_pkg::CH_LBRACKET, jtl_pkg::CH_COMMA, jtl_pkg::CH_RBRACKET};

	// One byte to offer. When known is set, the token fields hold the single
	// token this byte must produce, typed in by hand.
	typedef struct packed {
		logic [7:0]  ch;
		logic        eoi;
		logic        known;
		logic [3:0]  kind;
		logic [1:0]  code;
		logic [31:0] start;
		logic [31:0] length;
	} plan_row_t;

	// Directed opening: punctuators, a string with an escape, a fraction ended by
	// a comma (two tokens from one byte), null, a leading zero, an unknown byte
	// that halts the lexer, an ignored byte while halted, the end flag with a
	// junk byte, a broken number, the zero byte as end, and an open string at end.
	localparam plan_row_t PLAN [26] = '{
		'{jtl_pkg::CH_LBRACE, 1'b0, 1'b1, jtl_pkg::KIND_LBRACE, jtl_pkg::ERR_OK, 32'd0, 32'd1},
		'{jtl_pkg::CH_QUOTE, 1'b0, 1'b0, jtl_pkg::KIND_STRING, jtl_pkg::ERR_OK, 32'd0, 32'd0},
		'{jtl_pkg::CH_BSLASH, 1'b0, 1'b0, jtl_pkg::KIND_STRING, jtl_pkg::ERR_OK, 32'd0, 32'd0},
		'{jtl_pkg::CH_SLASH, 1'b0, 1'b0, jtl_pkg::KIND_STRING, jtl_pkg::ERR_OK, 32'd0, 32'd0},
		'{jtl_pkg::CH_QUOTE, 1'b0, 1'b0, jtl_pkg::KIND_STRING, jtl_pkg::ERR_OK, 32'd0, 32'd0},
		'{jtl_pkg::CH_COLON, 1'b0, 1'b1, jtl_pkg::KIND_COLON, jtl_pkg::ERR_OK, 32'd5, 32'd1},
		'{jtl_pkg::CH_MINUS, 1'b0, 1'b0, jtl_pkg::KIND_STRING, jtl_pkg::ERR_OK, 32'd0, 32'd0},
		'{jtl_pkg::CH_ZERO, 1'b0, 1'b0, jtl_pkg::KIND_STRING, jtl_pkg::ERR_OK, 32'd0, 32'd0},
		'{jtl_pkg::CH_DOT, 1'b0, 1'b0, jtl_pkg::KIND_STRING, jtl_pkg::ERR_OK, 32'd0, 32'd0},
		'{"5", 1'b0, 1'b0, jtl_pkg::KIND_STRING, jtl_pkg::ERR_OK, 32'd0, 32'd0},
		'{jtl_pkg::CH_COMMA, 1'b0, 1'b0, jtl_pkg::KIND_STRING, jtl_pkg::ERR_OK, 32'd0, 32'd0},
		'{jtl_pkg::CH_LOW_N, 1'b0, 1'b0, jtl_pkg::KIND_STRING, jtl_pkg::ERR_OK, 32'd0, 32'd0},
		'{"u", 1'b0, 1'b0, jtl_pkg::KIND_STRING, jtl_pkg::ERR_OK, 32'd0, 32'd0},
		'{"l", 1'b0, 1'b0, jtl_pkg::KIND_STRING, jtl_pkg::ERR_OK, 32'd0, 32'd0},
		'{"l", 1'b0, 1'b0, jtl_pkg::KIND_STRING, jtl_pkg::ERR_OK, 32'd0, 32'd0},
		'{jtl_pkg::CH_ZERO, 1'b0, 1'b0, jtl_pkg::KIND_STRING, jtl_pkg::ERR_OK, 32'd0, 32'd0},
		'{jtl_pkg::CH_ONE, 1'b0, 1'b0, jtl_pkg::KIND_STRING, jtl_pkg::ERR_OK, 32'd0, 32'd0},
		'{jtl_pkg::CH_RBRACKET, 1'b0, 1'b0, jtl_pkg::KIND_STRING, jtl_pkg::ERR_OK,
			32'd0, 32'd0},
		'{8'hFF, 1'b0, 1'b1, jtl_pkg::KIND_ERROR, jtl_pkg::ERR_TOKEN, 32'd18, 32'd1},
		'{"x", 1'b0, 1'b0, jtl_pkg::KIND_STRING, jtl_pkg::ERR_OK, 32'd0, 32'd0},
		'{"a", 1'b1, 1'b1, jtl_pkg::KIND_END, jtl_pkg::ERR_OK, 32'd19, 32'd0},
		'{jtl_pkg::CH_MINUS, 1'b0, 1'b0, jtl_pkg::KIND_STRING, jtl_pkg::ERR_OK, 32'd0, 32'd0},
		'{"q", 1'b0, 1'b1, jtl_pkg::KIND_ERROR, jtl_pkg::ERR_NUMBER, 32'd0, 32'd2},
		'{CH_NUL, 1'b0, 1'b1, jtl_pkg::KIND_END, jtl_pkg::ERR_OK, 32'd2, 32'd0},
		'{jtl_pkg::CH_QUOTE, 1'b0, 1'b0, jtl_pkg::KIND_STRING, jtl_pkg::ERR_OK, 32'd0, 32'd0},
		'{CH_NUL, 1'b0, 1'b0, jtl_pkg::KIND_STRING, jtl_pkg::ERR_OK, 32'd0, 32'd0}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        data_valid = 1'b0;
	logic        data_ready;
	logic [7:0]  text_byte = 8'h00;
	logic        end_of_input = 1'b0;
	logic        token_valid;
	logic        token_ready = 1'b0;
	logic [3:0]  token_kind;
	logic [1:0]  error_code;
	logic [31:0] token_start;
	logic [31:0] token_length;
	logic        last;

	json_token_lexer_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.data_valid   (data_valid),
		.data_ready   (data_ready),
		.text_byte    (text_byte),
		.end_of_input (end_of_input),
		.token_valid  (token_valid),
		.token_ready  (token_ready),
		.token_kind   (token_kind),
		.error_code   (error_code),
		.token_start  (token_start),
		.token_length (token_length),
		.last         (last)
	);

	always begin
		#5ns clk = 1'b1;
		#5ns clk = 1'b0;
	end

	// Lexer state as the testbench sees it.
	jtl_pkg::mode_t lx_mode;
	logic [1:0]     lx_sel;
	logic [2:0]     lx_idx;
	logic [31:0]    lx_pos;
	logic [31:0]    lx_start;
	logic [31:0]    lx_run;

	// Tokens produced by the byte being predicted, and the tokens still owed.
	jtl_pkg::entry_t step_toks [2];
	int              step_n;
	jtl_pkg::entry_t pending_tokens [$];
	plan_row_t       doc_q [$];

	int          mismatches = 0;
	bit          send_calm = 1'b0;

	function automatic void clear_lexer();
		lx_mode = jtl_pkg::M_IDLE;
		lx_sel = jtl_pkg::LIT_TRUE;
		lx_idx = '0;
		lx_pos = '0;
		lx_start = '0;
		lx_run = '0;
	endfunction

	function automatic logic [31:0] sat_inc(input logic [31:0] v);
		return (v == '1) ? v : v + 32'd1;
	endfunction

	function automatic void add_tok(input logic [3:0] kind, input logic [1:0] code,
		input logic [31:0] start, input logic [31:0] length);
		step_toks[step_n].res.kind = kind;
		step_toks[step_n].res.code = code;
		step_toks[step_n].res.start = start;
		step_toks[step_n].res.length = length;
		step_toks[step_n].last = 1'b0;
		step_n++;
	endfunction

	// The failing token is reported up to and including the offending byte.
	function automatic void halt_on(input logic [1:0] code);
		add_tok(jtl_pkg::KIND_ERROR, code, lx_start, sat_inc(lx_run));
		lx_mode = jtl_pkg::M_HALT;
	endfunction

	function automatic void open_run(input jtl_pkg::mode_t m, input logic [31:0] pos);
		lx_mode = m;
		lx_start = pos;
		lx_run = 32'd1;
	endfunction

	// A byte seen between tokens.
	function automatic void open_token(input logic [7:0] ch, input logic [31:0] pos);
		lx_mode = jtl_pkg::M_IDLE;
		case (ch)
			jtl_pkg::CH_TAB, jtl_pkg::CH_LF, jtl_pkg::CH_CR, jtl_pkg::CH_SPACE: ;
			jtl_pkg::CH_LBRACE:   add_tok(jtl_pkg::KIND_LBRACE, jtl_pkg::ERR_OK, pos, 32'd1);
			jtl_pkg::CH_COLON:    add_tok(jtl_pkg::KIND_COLON, jtl_pkg::ERR_OK, pos, 32'd1);
			jtl_pkg::CH_RBRACE:   add_tok(jtl_pkg::KIND_RBRACE, jtl_pkg::ERR_OK, pos, 32'd1);
			jtl_pkg::CH_LBRACKET: add_tok(jtl_pkg::KIND_LBRACKET, jtl_pkg::ERR_OK, pos, 32'd1);
			jtl_pkg::CH_COMMA:    add_tok(jtl_pkg::KIND_COMMA, jtl_pkg::ERR_OK, pos, 32'd1);
			jtl_pkg::CH_RBRACKET: add_tok(jtl_pkg::KIND_RBRACKET, jtl_pkg::ERR_OK, pos, 32'd1);
			jtl_pkg::CH_QUOTE:    open_run(jtl_pkg::M_STR, pos);
			jtl_pkg::CH_MINUS:    open_run(jtl_pkg::M_NSIGN, pos);
			jtl_pkg::CH_ZERO:     open_run(jtl_pkg::M_NZERO, pos);
			jtl_pkg::CH_LOW_T, jtl_pkg::CH_LOW_F, jtl_pkg::CH_LOW_N: begin
				open_run(jtl_pkg::M_LIT, pos);
				lx_sel = (ch == jtl_pkg::CH_LOW_T) ? jtl_pkg::LIT_TRUE :
					(ch == jtl_pkg::CH_LOW_F) ? jtl_pkg::LIT_FALSE : jtl_pkg::LIT_NULL;
				lx_idx = 3'd1;
			end
			default: begin
				if (ch inside {[jtl_pkg::CH_ONE:jtl_pkg::CH_NINE]}) begin
					open_run(jtl_pkg::M_NINT, pos);
				end else begin
					add_tok(jtl_pkg::KIND_ERROR, jtl_pkg::ERR_TOKEN, pos, 32'd1);
					lx_mode = jtl_pkg::M_HALT;
				end
			end
		endcase
	endfunction

	// A number only ends when a byte that cannot extend it arrives; that byte
	// is then handled as the start of whatever follows.
	function automatic void close_number(input logic [7:0] ch, input logic [31:0] pos);
		add_tok(jtl_pkg::KIND_NUMBER, jtl_pkg::ERR_OK, lx_start, lx_run);
		open_token(ch, pos);
	endfunction

	// Advances the lexer by one accepted item and fills step_toks. A data byte
	// that a halted lexer ignores leaves step_toks empty.
	function automatic void lex_byte(input logic [7:0] ch, input logic eoi);
		logic [31:0] here;
		string       word;
		step_n = 0;
		if (eoi || ch == CH_NUL) begin
			// End marker: flush whatever token is open, then the end token.
			case (lx_mode)
				jtl_pkg::M_STR, jtl_pkg::M_ESC:
					add_tok(jtl_pkg::KIND_ERROR, jtl_pkg::ERR_STRING, lx_start, lx_run);
				jtl_pkg::M_NSIGN, jtl_pkg::M_NDOT:
					add_tok(jtl_pkg::KIND_ERROR, jtl_pkg::ERR_NUMBER, lx_start, lx_run);
				jtl_pkg::M_NZERO, jtl_pkg::M_NINT, jtl_pkg::M_NFRAC:
					add_tok(jtl_pkg::KIND_NUMBER, jtl_pkg::ERR_OK, lx_start, lx_run);
				jtl_pkg::M_LIT:
					add_tok(jtl_pkg::KIND_ERROR, jtl_pkg::ERR_TOKEN, lx_start, lx_run);
				default: ;
			endcase
			add_tok(jtl_pkg::KIND_END, jtl_pkg::ERR_OK, lx_pos, 32'd0);
			clear_lexer();
		end else if (lx_mode != jtl_pkg::M_HALT) begin
			here = lx_pos;
			lx_pos = lx_pos + 32'd1;
			case (lx_mode)
				jtl_pkg::M_STR: begin
					lx_run = sat_inc(lx_run);
					if (ch == jtl_pkg::CH_BSLASH) begin
						lx_mode = jtl_pkg::M_ESC;
					end else if (ch == jtl_pkg::CH_QUOTE) begin
						add_tok(jtl_pkg::KIND_STRING, jtl_pkg::ERR_OK, lx_start, lx_run);
						lx_mode = jtl_pkg::M_IDLE;
					end
				end
				jtl_pkg::M_ESC: begin
					if (ch inside {jtl_pkg::CH_QUOTE, jtl_pkg::CH_BSLASH, jtl_pkg::CH_SLASH,
						jtl_pkg::CH_LOW_B, jtl_pkg::CH_LOW_F, jtl_pkg::CH_LOW_N,
						jtl_pkg::CH_LOW_R, jtl_pkg::CH_LOW_T}) begin
						lx_run = sat_inc(lx_run);
						lx_mode = jtl_pkg::M_STR;
					end else begin
						halt_on(jtl_pkg::ERR_STRING);
					end
				end
				jtl_pkg::M_NSIGN: begin
					if (ch == jtl_pkg::CH_ZERO) begin
						lx_run = sat_inc(lx_run);
						lx_mode = jtl_pkg::M_NZERO;
					end else if (ch inside {[jtl_pkg::CH_ONE:jtl_pkg::CH_NINE]}) begin
						lx_run = sat_inc(lx_run);
						lx_mode = jtl_pkg::M_NINT;
					end else begin
						halt_on(jtl_pkg::ERR_NUMBER);
					end
				end
				jtl_pkg::M_NZERO: begin
					if (ch == jtl_pkg::CH_DOT) begin
						lx_run = sat_inc(lx_run);
						lx_mode = jtl_pkg::M_NDOT;
					end else begin
						close_number(ch, here);
					end
				end
				jtl_pkg::M_NINT: begin
					if (ch inside {[jtl_pkg::CH_ZERO:jtl_pkg::CH_NINE]}) begin
						lx_run = sat_inc(lx_run);
					end else if (ch == jtl_pkg::CH_DOT) begin
						lx_run = sat_inc(lx_run);
						lx_mode = jtl_pkg::M_NDOT;
					end else begin
						close_number(ch, here);
					end
				end
				jtl_pkg::M_NDOT: begin
					if (ch inside {[jtl_pkg::CH_ZERO:jtl_pkg::CH_NINE]}) begin
						lx_run = sat_inc(lx_run);
						lx_mode = jtl_pkg::M_NFRAC;
					end else begin
						halt_on(jtl_pkg::ERR_NUMBER);
					end
				end
				jtl_pkg::M_NFRAC: begin
					if (ch inside {[jtl_pkg::CH_ZERO:jtl_pkg::CH_NINE]}) begin
						lx_run = sat_inc(lx_run);
					end else begin
						close_number(ch, here);
					end
				end
				jtl_pkg::M_LIT: begin
					case (lx_sel)
						jtl_pkg::LIT_TRUE:  word = "true";
						jtl_pkg::LIT_FALSE: word = "false";
						jtl_pkg::LIT_NULL:  word = "null";
						default:            word = "";
					endcase
					if (lx_idx < word.len() && ch == word[lx_idx]) begin
						lx_run = sat_inc(lx_run);
						lx_idx = lx_idx + 3'd1;
						if (lx_idx == word.len()) begin
							add_tok(jtl_pkg::KIND_TRUE + {2'b00, lx_sel}, jtl_pkg::ERR_OK,
								lx_start, lx_run);
							lx_mode = jtl_pkg::M_IDLE;
							lx_sel = jtl_pkg::LIT_TRUE;
							lx_idx = '0;
						end
					end else begin
						halt_on(jtl_pkg::ERR_TOKEN);
					end
				end
				default: open_token(ch, here);
			endcase
		end
		if (step_n > 0)
			step_toks[step_n - 1].last = 1'b1;
	endfunction

	function automatic void queue_byte(input logic [7:0] ch, input logic eoi);
		plan_row_t row;
		row = '0;
		row.ch = ch;
		row.eoi = eoi;
		doc_q.push_back(row);
	endfunction

	// Builds one random document: mostly well-formed tokens with random content
	// and optional whitespace, a sprinkling of broken tokens and stray bytes,
	// closed by either the end flag or the zero byte.
	function automatic void compose_document();
		int         n_tok;
		int         t;
		int         k;
		int         bad;
		logic [7:0] c;
		string      word;
		n_tok = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 16);
		for (t = 0; t < n_tok; t++) begin
			if ($urandom_range(0, 2) == 0)
				repeat ($urandom_range(1, 3)) queue_byte(BLANKS[$urandom_range(0, 3)], 1'b0);
			case ($urandom_range(0, 29))
				0, 1, 2, 3, 4, 5, 6, 7: begin
					queue_byte(jtl_pkg::CH_QUOTE, 1'b0);
					repeat ($urandom_range(0, 10)) begin
						if ($urandom_range(0, 7) == 0) begin
							queue_byte(jtl_pkg::CH_BSLASH, 1'b0);
							if ($urandom_range(0, 24) == 0)
								queue_byte(8'($urandom_range(1, 255)), 1'b0);
							else
								queue_byte(ESCAPES[$urandom_range(0, 7)], 1'b0);
						end else begin
							c = 8'($urandom_range(1, 255));
							if (c == jtl_pkg::CH_QUOTE || c == jtl_pkg::CH_BSLASH)
								c = jtl_pkg::CH_SPACE;
							queue_byte(c, 1'b0);
						end
					end
					if ($urandom_range(0, 19) != 0)
						queue_byte(jtl_pkg::CH_QUOTE, 1'b0);
				end
				8, 9, 10, 11, 12, 13, 14, 15: begin
					if ($urandom_range(0, 2) == 0)
						queue_byte(jtl_pkg::CH_MINUS, 1'b0);
					// Now and then the integer part is missing altogether.
					if ($urandom_range(0, 29) == 0) begin
					end else if ($urandom_range(0, 3) == 0) begin
						queue_byte(jtl_pkg::CH_ZERO, 1'b0);
					end else begin
						queue_byte(8'($urandom_range(jtl_pkg::CH_ONE, jtl_pkg::CH_NINE)), 1'b0);
						repeat ($urandom_range(0, 5))
							queue_byte(8'(jtl_pkg::CH_ZERO + $urandom_range(0, 9)), 1'b0);
					end
					if ($urandom_range(0, 2) == 0) begin
						queue_byte(jtl_pkg::CH_DOT, 1'b0);
						repeat (($urandom_range(0, 14) == 0) ? 0 : $urandom_range(1, 4))
							queue_byte(8'(jtl_pkg::CH_ZERO + $urandom_range(0, 9)), 1'b0);
					end
				end
				16, 17, 18, 19, 20, 21: begin
					case ($urandom_range(0, 2))
						0:       word = "true";
						1:       word = "false";
						default: word = "null";
					endcase
					bad = ($urandom_range(0, 14) == 0) ? $urandom_range(0, word.len() - 1) : -1;
					for (k = 0; k < word.len(); k++)
						queue_byte((k == bad) ? 8'($urandom_range(1, 255)) : word[k], 1'b0);
				end
				29: queue_byte(8'($urandom_range(1, 255)), 1'b0);
				default: queue_byte(PUNCTS[$urandom_range(0, 5)], 1'b0);
			endcase
		end
		if ($urandom_range(0, 1) == 0)
			queue_byte(8'($urandom_range(0, 255)), 1'b1);
		else
			queue_byte(CH_NUL, 1'b0);
	endfunction

	// Offers one item after a random gap, records the tokens it must produce,
	// and returns once the lexer has taken it.
	task automatic send_item(input plan_row_t row);
		int              gap;
		int              i;
		jtl_pkg::entry_t want;
		if ($urandom_range(0, 63) == 0)
			send_calm = !send_calm;
		gap = send_calm ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			data_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		data_valid <= 1'b1;
		text_byte <= row.ch;
		end_of_input <= row.eoi;
		// The item is sure to be taken, so its tokens are owed from now on.
		lex_byte(row.ch, row.eoi);
		if (row.known) begin
			want.res.kind = row.kind;
			want.res.code = row.code;
			want.res.start = row.start;
			want.res.length = row.length;
			want.last = 1'b1;
			pending_tokens.push_back(want);
		end else begin
			for (i = 0; i < step_n; i++)
				pending_tokens.push_back(step_toks[i]);
		end
		do @(posedge clk); while (!data_ready);
	endtask

	// Token side: random stalls, calm stretches, one long choke, and a
	// field-by-field comparison against the oldest owed token.
	initial begin : token_sink
		int              stall;
		int              got;
		bit              calm;
		jtl_pkg::entry_t want;
		got = 0;
		calm = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if ($urandom_range(0, 47) == 0)
				calm = !calm;
			stall = calm ? 0 : $urandom_range(0, MAX_GAP);
			if (got == CHOKE_AFTER)
				stall = CHOKE_CYCLES;
			if (stall > 0) begin
				token_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			token_ready <= 1'b1;
			do @(posedge clk); while (!token_valid);
			got++;
			if (pending_tokens.size() == 0) begin
				$error("unexpected token: kind %0d start %0d", token_kind, token_start);
				mismatches++;
			end else begin
				want = pending_tokens.pop_front();
				if (token_kind !== want.res.kind) begin
					$error("token_kind: expected %0d, got %0d", want.res.kind, token_kind);
					mismatches++;
				end
				if (error_code !== want.res.code) begin
					$error("error_code: expected %0d, got %0d", want.res.code, error_code);
					mismatches++;
				end
				if (token_start !== want.res.start) begin
					$error("token_start: expected %0d, got %0d", want.res.start, token_start);
					mismatches++;
				end
				if (token_length !== want.res.length) begin
					$error("token_length: expected %0d, got %0d", want.res.length,
						token_length);
					mismatches++;
				end
				if (last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, last);
					mismatches++;
				end
			end
		end
	end

	// Ends the run if neither channel moves for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if ((data_valid && data_ready) || (token_valid && token_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet == STALL_LIMIT) begin
				$error("no handshake on either channel for %0d cycles", STALL_LIMIT);
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int        r;
		int        sent_items;
		plan_row_t row;
		clear_lexer();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (r = 0; r < $size(PLAN); r++)
			send_item(PLAN[r]);

		// Whole documents are sent until the random total is reached.
		sent_items = 0;
		while (sent_items < RANDOM_ITEMS) begin
			compose_document();
			while (doc_q.size() != 0) begin
				row = doc_q.pop_front();
				send_item(row);
				sent_items++;
			end
		end
		data_valid <= 1'b0;

		while (pending_tokens.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
